@@ design/tsmf_pkg.sv @@
// Shared constants, codes and transfer types of the topological sorter.
`timescale 1ns / 1ps

package tsmf_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;

    localparam int ID_W    = 7;
    localparam int VIDX_W  = $clog2(MAX_VERTICES);
    localparam int VCNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int EADDR_W = $clog2(MAX_EDGES);
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
    localparam int DEG_W   = ECNT_W;
    localparam int EDGE_W  = 2 * ID_W;

    localparam logic [1:0] OP_CLEAR    = 2'd0;
    localparam logic [1:0] OP_ADD_VERT = 2'd1;
    localparam logic [1:0] OP_ADD_EDGE = 2'd2;
    localparam logic [1:0] OP_RUN      = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CYCLE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]      opcode;
        logic [ID_W-1:0] from_vertex;
        logic [ID_W-1:0] to_vertex;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0] vertex;
        logic            last;
        logic [1:0]      status;
    } result_t;

endpackage

@@ design/topological_sort_min_first.sv @@
// Top level of the min-first topological sorter: memories, sequencer, output register.
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+-------------------------------
//   items    | item_valid   | item_stall   | item   (opcode, from, to)
//   results  | result_valid | result_stall | result (vertex, last, status)
//
// Clear, add-vertex and add-edge items are taken back to back when not stalled.
// A run: accept, in-degree clear, count walk over the edges, ready scan, then
// per ordered vertex a pick and an edge walk, then a last pick and a finish,
// then a read and an output per emitted vertex; the serial edge walks set the
// pace. Reset clears control state. A stalled result holds in the output
// register; items stall while it is full and stalled, and during a run.
`timescale 1ns / 1ps

module topological_sort_min_first (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  tsmf_pkg::item_t     item,
    output logic                result_valid,
    input  logic                result_stall,
    output tsmf_pkg::result_t   result
);

    logic                          res_valid;
    logic                          res_ready;
    tsmf_pkg::result_t             res;

    logic                          edge_we, edge_re;
    logic [tsmf_pkg::EADDR_W-1:0]  edge_waddr, edge_raddr;
    logic [tsmf_pkg::EDGE_W-1:0]   edge_wdata, edge_rdata;
    logic                          deg_we, deg_re;
    logic [tsmf_pkg::VIDX_W-1:0]   deg_waddr, deg_raddr;
    logic [tsmf_pkg::DEG_W-1:0]    deg_wdata, deg_rdata;
    logic                          ord_we, ord_re;
    logic [tsmf_pkg::VIDX_W-1:0]   ord_waddr, ord_raddr;
    logic [tsmf_pkg::ID_W-1:0]     ord_wdata, ord_rdata;

    logic                          result_valid_reg;
    tsmf_pkg::result_t             result_reg;

    assign res_ready = !result_valid_reg || !result_stall;

    tsmf_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .edge_we    (edge_we),
        .edge_waddr (edge_waddr),
        .edge_wdata (edge_wdata),
        .edge_re    (edge_re),
        .edge_raddr (edge_raddr),
        .edge_rdata (edge_rdata),
        .deg_we     (deg_we),
        .deg_waddr  (deg_waddr),
        .deg_wdata  (deg_wdata),
        .deg_re     (deg_re),
        .deg_raddr  (deg_raddr),
        .deg_rdata  (deg_rdata),
        .ord_we     (ord_we),
        .ord_waddr  (ord_waddr),
        .ord_wdata  (ord_wdata),
        .ord_re     (ord_re),
        .ord_raddr  (ord_raddr),
        .ord_rdata  (ord_rdata)
    );

    tsmf_ram #(
        .WIDTH (tsmf_pkg::EDGE_W),
        .DEPTH (tsmf_pkg::MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .re    (edge_re),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    tsmf_ram #(
        .WIDTH (tsmf_pkg::DEG_W),
        .DEPTH (tsmf_pkg::MAX_VERTICES)
    ) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .re    (deg_re),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    tsmf_ram #(
        .WIDTH (tsmf_pkg::ID_W),
        .DEPTH (tsmf_pkg::MAX_VERTICES)
    ) u_ord_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .re    (ord_re),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            result_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ design/tsmf_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps

module tsmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/tsmf_seq.sv @@
// Graph loader and sort sequencer: vertex maps, edge walks, order readout.
`timescale 1ns / 1ps

module tsmf_seq (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  tsmf_pkg::item_t                  item,
    output logic                             res_valid,
    input  logic                             res_ready,
    output tsmf_pkg::result_t                res,
    output logic                             edge_we,
    output logic [tsmf_pkg::EADDR_W-1:0]     edge_waddr,
    output logic [tsmf_pkg::EDGE_W-1:0]      edge_wdata,
    output logic                             edge_re,
    output logic [tsmf_pkg::EADDR_W-1:0]     edge_raddr,
    input  logic [tsmf_pkg::EDGE_W-1:0]      edge_rdata,
    output logic                             deg_we,
    output logic [tsmf_pkg::VIDX_W-1:0]      deg_waddr,
    output logic [tsmf_pkg::DEG_W-1:0]       deg_wdata,
    output logic                             deg_re,
    output logic [tsmf_pkg::VIDX_W-1:0]      deg_raddr,
    input  logic [tsmf_pkg::DEG_W-1:0]       deg_rdata,
    output logic                             ord_we,
    output logic [tsmf_pkg::VIDX_W-1:0]      ord_waddr,
    output logic [tsmf_pkg::ID_W-1:0]        ord_wdata,
    output logic                             ord_re,
    output logic [tsmf_pkg::VIDX_W-1:0]      ord_raddr,
    input  logic [tsmf_pkg::ID_W-1:0]        ord_rdata
);

    localparam int VW = tsmf_pkg::VIDX_W;
    localparam int CW = tsmf_pkg::VCNT_W;
    localparam int EW = tsmf_pkg::ECNT_W;
    localparam int IW = tsmf_pkg::ID_W;
    localparam int NV = tsmf_pkg::MAX_VERTICES;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLR     = 4'd1;
    localparam logic [3:0] S_CNT_RD  = 4'd2;
    localparam logic [3:0] S_CNT_DG  = 4'd3;
    localparam logic [3:0] S_CNT_WR  = 4'd4;
    localparam logic [3:0] S_RDY_RD  = 4'd5;
    localparam logic [3:0] S_RDY_EV  = 4'd6;
    localparam logic [3:0] S_PICK    = 4'd7;
    localparam logic [3:0] S_WLK_RD  = 4'd8;
    localparam logic [3:0] S_WLK_DG  = 4'd9;
    localparam logic [3:0] S_WLK_WR  = 4'd10;
    localparam logic [3:0] S_FIN     = 4'd11;
    localparam logic [3:0] S_EMIT_RD = 4'd12;
    localparam logic [3:0] S_EMIT_WR = 4'd13;

    logic [3:0]    state_reg, state_next;
    logic [NV-1:0] present_reg, present_next;
    logic [NV-1:0] ready_reg, ready_next;
    logic [NV-1:0] done_reg, done_next;
    logic [EW-1:0] ecount_reg, ecount_next;
    logic [EW-1:0] eidx_reg, eidx_next;
    logic [CW-1:0] vidx_reg, vidx_next;
    logic [CW-1:0] len_reg, len_next;
    logic [VW-1:0] pick_reg, pick_next;
    logic [VW-1:0] dst_reg, dst_next;

    logic          accept;
    logic          from_ok, to_ok;
    logic [IW-1:0] from_m1, to_m1, edst_m1, esrc;
    logic          any_ready;
    logic [VW-1:0] first_ready;
    logic [VW-1:0] vidx_lo;
    logic          emit_last;

    function automatic logic id_ok(input logic [IW-1:0] v);
        return (v != '0) && (v <= IW'(NV));
    endfunction

    assign accept   = item_valid && !item_stall;
    assign from_ok  = id_ok(item.from_vertex);
    assign to_ok    = id_ok(item.to_vertex);
    assign from_m1  = item.from_vertex - IW'(1);
    assign to_m1    = item.to_vertex - IW'(1);
    assign edst_m1  = edge_rdata[IW-1:0] - IW'(1);
    assign esrc     = edge_rdata[2*IW-1:IW];
    assign vidx_lo  = vidx_reg[VW-1:0];
    assign emit_last = (vidx_reg + CW'(1)) == len_reg;

    // lowest-numbered ready vertex
    always_comb
    begin
        any_ready   = |ready_reg;
        first_ready = '0;
        for (int i = NV - 1; i >= 0; i--)
        begin
            if (ready_reg[i])
            begin
                first_ready = VW'(i);
            end
        end
    end

    assign item_stall = (state_reg != S_IDLE) || !res_ready;

    always_comb
    begin
        state_next   = state_reg;
        present_next = present_reg;
        ready_next   = ready_reg;
        done_next    = done_reg;
        ecount_next  = ecount_reg;
        eidx_next    = eidx_reg;
        vidx_next    = vidx_reg;
        len_next     = len_reg;
        pick_next    = pick_reg;
        dst_next     = dst_reg;

        res_valid    = 1'b0;
        res.vertex   = '0;
        res.last     = 1'b1;
        res.status   = tsmf_pkg::ST_OK;

        edge_we    = 1'b0;
        edge_waddr = ecount_reg[tsmf_pkg::EADDR_W-1:0];
        edge_wdata = {item.from_vertex, item.to_vertex};
        edge_re    = 1'b0;
        edge_raddr = eidx_reg[tsmf_pkg::EADDR_W-1:0];
        deg_we     = 1'b0;
        deg_waddr  = dst_reg;
        deg_wdata  = '0;
        deg_re     = 1'b0;
        deg_raddr  = edst_m1[VW-1:0];
        ord_we     = 1'b0;
        ord_waddr  = len_reg[VW-1:0];
        ord_wdata  = IW'(first_ready) + IW'(1);
        ord_re     = 1'b0;
        ord_raddr  = vidx_lo;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.opcode)
                        tsmf_pkg::OP_CLEAR:
                        begin
                            res_valid    = 1'b1;
                            present_next = '0;
                            ready_next   = '0;
                            ecount_next  = '0;
                            len_next     = '0;
                        end
                        tsmf_pkg::OP_ADD_VERT:
                        begin
                            res_valid = 1'b1;
                            if (from_ok)
                            begin
                                present_next[from_m1[VW-1:0]] = 1'b1;
                            end
                        end
                        tsmf_pkg::OP_ADD_EDGE:
                        begin
                            res_valid = 1'b1;
                            if (from_ok && to_ok)
                            begin
                                if (ecount_reg == EW'(tsmf_pkg::MAX_EDGES))
                                begin
                                    res.status = tsmf_pkg::ST_FULL;
                                end
                                else
                                begin
                                    edge_we     = 1'b1;
                                    ecount_next = ecount_reg + EW'(1);
                                    present_next[from_m1[VW-1:0]] = 1'b1;
                                    present_next[to_m1[VW-1:0]]   = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            if (present_reg == '0)
                            begin
                                res_valid  = 1'b1;
                                res.status = tsmf_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ready_next = '0;
                                done_next  = '0;
                                len_next   = '0;
                                vidx_next  = '0;
                                state_next = S_CLR;
                            end
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                deg_we    = 1'b1;
                deg_waddr = vidx_lo;
                if (vidx_reg == CW'(NV - 1))
                begin
                    eidx_next  = '0;
                    state_next = S_CNT_RD;
                end
                else
                begin
                    vidx_next = vidx_reg + CW'(1);
                end
            end
            S_CNT_RD:
            begin
                if (eidx_reg == ecount_reg)
                begin
                    vidx_next  = '0;
                    state_next = S_RDY_RD;
                end
                else
                begin
                    edge_re    = 1'b1;
                    state_next = S_CNT_DG;
                end
            end
            S_CNT_DG:
            begin
                deg_re     = 1'b1;
                dst_next   = edst_m1[VW-1:0];
                state_next = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                deg_we     = 1'b1;
                deg_wdata  = deg_rdata + tsmf_pkg::DEG_W'(1);
                eidx_next  = eidx_reg + EW'(1);
                state_next = S_CNT_RD;
            end
            S_RDY_RD:
            begin
                deg_re     = 1'b1;
                deg_raddr  = vidx_lo;
                state_next = S_RDY_EV;
            end
            S_RDY_EV:
            begin
                if (present_reg[vidx_lo] && deg_rdata == '0)
                begin
                    ready_next[vidx_lo] = 1'b1;
                end
                if (vidx_reg == CW'(NV - 1))
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    vidx_next  = vidx_reg + CW'(1);
                    state_next = S_RDY_RD;
                end
            end
            S_PICK:
            begin
                if (!any_ready)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ready_next[first_ready] = 1'b0;
                    done_next[first_ready]  = 1'b1;
                    ord_we     = 1'b1;
                    len_next   = len_reg + CW'(1);
                    pick_next  = first_ready;
                    eidx_next  = '0;
                    state_next = S_WLK_RD;
                end
            end
            S_WLK_RD:
            begin
                if (eidx_reg == ecount_reg)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    edge_re    = 1'b1;
                    state_next = S_WLK_DG;
                end
            end
            S_WLK_DG:
            begin
                if (esrc == IW'(pick_reg) + IW'(1))
                begin
                    deg_re     = 1'b1;
                    dst_next   = edst_m1[VW-1:0];
                    state_next = S_WLK_WR;
                end
                else
                begin
                    eidx_next  = eidx_reg + EW'(1);
                    state_next = S_WLK_RD;
                end
            end
            S_WLK_WR:
            begin
                if (deg_rdata != '0)
                begin
                    deg_we    = 1'b1;
                    deg_wdata = deg_rdata - tsmf_pkg::DEG_W'(1);
                    if (deg_rdata == tsmf_pkg::DEG_W'(1))
                    begin
                        ready_next[dst_reg] = 1'b1;
                    end
                end
                eidx_next  = eidx_reg + EW'(1);
                state_next = S_WLK_RD;
            end
            S_FIN:
            begin
                if ((present_reg & ~done_reg) != '0)
                begin
                    res_valid  = 1'b1;
                    res.status = tsmf_pkg::ST_CYCLE;
                    if (res_ready)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    vidx_next  = '0;
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                ord_re     = 1'b1;
                state_next = S_EMIT_WR;
            end
            S_EMIT_WR:
            begin
                res_valid  = 1'b1;
                res.vertex = ord_rdata;
                res.last   = emit_last;
                if (res_ready)
                begin
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        vidx_next  = vidx_reg + CW'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            present_reg <= '0;
            ready_reg   <= '0;
            done_reg    <= '0;
            ecount_reg  <= '0;
            len_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            present_reg <= present_next;
            ready_reg   <= ready_next;
            done_reg    <= done_next;
            ecount_reg  <= ecount_next;
            len_reg     <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eidx_reg <= eidx_next;
        vidx_reg <= vidx_next;
        pick_reg <= pick_next;
        dst_reg  <= dst_next;
    end

endmodule

@@ verif/tb.sv @@
// Self-checking testbench of the min-first topological sorter.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int NV  = tsmf_pkg::MAX_VERTICES;
    localparam int IDW = tsmf_pkg::ID_W;
    localparam int EDW = tsmf_pkg::EDGE_W;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    tsmf_pkg::item_t   item;
    logic              result_valid;
    logic              result_stall;
    tsmf_pkg::result_t result;

    topological_sort_min_first DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Graph model
    logic              vert_present [1:NV] = '{default: 1'b0};
    logic [EDW-1:0]    edge_list    [tsmf_pkg::MAX_EDGES];
    int                num_edges = 0;

    tsmf_pkg::item_t   pending_items [$];
    tsmf_pkg::result_t expected_results [$];
    int                send_idle_pct;
    int                recv_idle_pct;
    bit                hold_off;
    int                fail_count = 0;
    int                quiet_cycles = 0;

    function automatic bit valid_id(logic [IDW-1:0] v);
        return v >= 1 && v <= NV;
    endfunction

    function automatic tsmf_pkg::result_t make_result(logic [IDW-1:0] v, logic l,
                                                      logic [1:0] s);
        tsmf_pkg::result_t r;
        r.vertex = v;
        r.last   = l;
        r.status = s;
        return r;
    endfunction

    task automatic expect_result(tsmf_pkg::result_t r);
        expected_results = {expected_results, r};
    endtask

    task automatic queue_item(tsmf_pkg::item_t it);
        pending_items = {pending_items, it};
    endtask

    // Predicts the sort over the current graph and queues its results.
    task automatic predict_sort();
        int  deg [1:NV];
        bit  rdy [1:NV];
        int  order [$];
        int  present;
        int  pick;
        int  src;
        int  dst;
        present = 0;
        for (int v = 1; v <= NV; v++)
        begin
            deg[v] = 0;
            rdy[v] = 0;
            if (vert_present[v])
                present++;
        end
        if (present == 0)
        begin
            expect_result(make_result('0, 1'b1, tsmf_pkg::ST_EMPTY));
            return;
        end
        for (int e = 0; e < num_edges; e++)
            deg[edge_list[e][IDW-1:0]]++;
        for (int v = 1; v <= NV; v++)
            if (vert_present[v] && deg[v] == 0)
                rdy[v] = 1;
        forever
        begin
            pick = 0;
            for (int v = 1; v <= NV; v++)
                if (rdy[v] && pick == 0)
                    pick = v;
            if (pick == 0 || order.size() >= NV)
                break;
            rdy[pick] = 0;
            order = {order, pick};
            for (int e = 0; e < num_edges; e++)
            begin
                src = edge_list[e][EDW-1:IDW];
                dst = edge_list[e][IDW-1:0];
                if (src == pick && deg[dst] > 0)
                begin
                    deg[dst]--;
                    if (deg[dst] == 0)
                        rdy[dst] = 1;
                end
            end
        end
        if (order.size() < present)
        begin
            expect_result(make_result('0, 1'b1, tsmf_pkg::ST_CYCLE));
            return;
        end
        foreach (order[i])
            expect_result(make_result(IDW'(order[i]), i == order.size() - 1,
                                      tsmf_pkg::ST_OK));
    endtask

    task automatic predict_item(tsmf_pkg::item_t it);
        case (it.opcode)
            tsmf_pkg::OP_CLEAR:
            begin
                for (int v = 1; v <= NV; v++)
                    vert_present[v] = 0;
                num_edges = 0;
                expect_result(make_result('0, 1'b1, tsmf_pkg::ST_OK));
            end
            tsmf_pkg::OP_ADD_VERT:
            begin
                if (valid_id(it.from_vertex))
                    vert_present[it.from_vertex] = 1;
                expect_result(make_result('0, 1'b1, tsmf_pkg::ST_OK));
            end
            tsmf_pkg::OP_ADD_EDGE:
            begin
                if (valid_id(it.from_vertex) && valid_id(it.to_vertex)
                    && num_edges >= tsmf_pkg::MAX_EDGES)
                    expect_result(make_result('0, 1'b1, tsmf_pkg::ST_FULL));
                else
                begin
                    if (valid_id(it.from_vertex) && valid_id(it.to_vertex))
                    begin
                        edge_list[num_edges] = {it.from_vertex, it.to_vertex};
                        num_edges++;
                        vert_present[it.from_vertex] = 1;
                        vert_present[it.to_vertex]   = 1;
                    end
                    expect_result(make_result('0, 1'b1, tsmf_pkg::ST_OK));
                end
            end
            default:
                predict_sort();
        endcase
    endtask

    function automatic tsmf_pkg::item_t mk_item(logic [1:0] op, int a, int b);
        tsmf_pkg::item_t it;
        it.opcode      = op;
        it.from_vertex = IDW'(a);
        it.to_vertex   = IDW'(b);
        return it;
    endfunction

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else if (!item_valid || !item_stall)
        begin
            if (pending_items.size() > 0 && !hold_off
                && $urandom_range(99) >= send_idle_pct)
            begin
                item_valid <= 1'b1;
                item       <= pending_items.pop_front();
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Prediction runs at acceptance so the queue stays in order.
    always @(posedge clk)
        if (rst_n && item_valid && !item_stall)
            predict_item(item);

    // Monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result vertex=%0d last=%0d status=%0d",
                           result.vertex, result.last, result.status);
                    fail_count++;
                end
                else
                begin
                    tsmf_pkg::result_t exp_r;
                    exp_r = expected_results.pop_front();
                    if (result.vertex !== exp_r.vertex)
                    begin
                        $error("vertex: expected %0d, got %0d", exp_r.vertex, result.vertex);
                        fail_count++;
                    end
                    if (result.last !== exp_r.last)
                    begin
                        $error("last: expected %0d, got %0d", exp_r.last, result.last);
                        fail_count++;
                    end
                    if (result.status !== exp_r.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_r.status, result.status);
                        fail_count++;
                    end
                end
            end
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic add_dag(int nv, int ne);
        int a;
        int b;
        for (int i = 0; i < ne; i++)
        begin
            a = $urandom_range(1, nv - 1);
            b = $urandom_range(a + 1, nv);
            queue_item(mk_item(tsmf_pkg::OP_ADD_EDGE, a, b));
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || item_valid || expected_results.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int n;
        int r;
        hold_off      = 0;
        send_idle_pct = 28;
        recv_idle_pct = 60;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part
        queue_item(mk_item(tsmf_pkg::OP_RUN, 0, 0));          // empty graph
        queue_item(mk_item(tsmf_pkg::OP_ADD_VERT, 0, 0));     // id 0 ignored
        queue_item(mk_item(tsmf_pkg::OP_ADD_VERT, 127, 0));   // id too high
        queue_item(mk_item(tsmf_pkg::OP_ADD_VERT, 65, 0));
        queue_item(mk_item(tsmf_pkg::OP_ADD_EDGE, 0, 5));
        queue_item(mk_item(tsmf_pkg::OP_ADD_EDGE, 5, 127));
        queue_item(mk_item(tsmf_pkg::OP_ADD_VERT, 64, 0));
        queue_item(mk_item(tsmf_pkg::OP_ADD_VERT, 1, 0));
        queue_item(mk_item(tsmf_pkg::OP_ADD_EDGE, 64, 3));
        queue_item(mk_item(tsmf_pkg::OP_ADD_EDGE, 3, 1));
        queue_item(mk_item(tsmf_pkg::OP_ADD_EDGE, 3, 1));     // duplicate edge
        queue_item(mk_item(tsmf_pkg::OP_RUN, 0, 0));
        queue_item(mk_item(tsmf_pkg::OP_ADD_EDGE, 2, 2));     // self loop
        queue_item(mk_item(tsmf_pkg::OP_RUN, 127, 127));
        queue_item(mk_item(tsmf_pkg::OP_CLEAR, 127, 127));
        queue_item(mk_item(tsmf_pkg::OP_ADD_EDGE, 1, 2));
        queue_item(mk_item(tsmf_pkg::OP_ADD_EDGE, 2, 1));     // two-vertex cycle
        queue_item(mk_item(tsmf_pkg::OP_RUN, 0, 0));
        queue_item(mk_item(tsmf_pkg::OP_CLEAR, 0, 0));
        wait_drained();

        // Random part, three idling phases
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 60 : 0;
            recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 28 : 0;
            for (int g = 0; g < 3; g++)
            begin
                queue_item(mk_item(tsmf_pkg::OP_CLEAR, $urandom_range(127),
                                   $urandom_range(127)));
                n = $urandom_range(2, 12);
                add_dag(n, $urandom_range(1, 10));
                r = $urandom_range(0, 3);
                for (int i = 0; i < r; i++)
                    queue_item(mk_item(($urandom_range(1) == 0) ? tsmf_pkg::OP_ADD_VERT
                                                                : tsmf_pkg::OP_ADD_EDGE,
                        $urandom_range(127), $urandom_range(127)));   // noise
                if ($urandom_range(2) == 0)
                begin
                    int a;
                    a = $urandom_range(1, n);
                    queue_item(mk_item(tsmf_pkg::OP_ADD_EDGE, a, a));
                end
                queue_item(mk_item(tsmf_pkg::OP_RUN, $urandom_range(127),
                                   $urandom_range(127)));
            end
            wait_drained();
            // Hold the sender off with an item queued, then release it and drain.
            hold_off = 1;
            queue_item(mk_item(tsmf_pkg::OP_ADD_VERT, $urandom_range(1, 64), 0));
            repeat (5) @(posedge clk);
            hold_off = 0;
            wait_drained();
        end

        repeat (200) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
design/tsmf_pkg.sv
design/tsmf_ram.sv
design/tsmf_seq.sv
design/topological_sort_min_first.sv
verif/tb.sv
